FILE: hdl/awd_pkg.sv
// Shared types, widths, constants and the arctangent table for the apparent wind block.
`timescale 1ns / 1ps
package awd_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int STG_W = $clog2(CORDIC_STAGES);
  // drag result delay taps, lines the drag path up with the vectoring path
  localparam int DLY = CORDIC_STAGES - 2;

  localparam int RW = 34;      // rotation datapath, speeds in Q16 of 1/64 kn
  localparam int VW = 36;      // vectoring datapath, grows by gain and sqrt(2)
  localparam int VZW = 32;     // vectoring angle, 2^32 per turn, wraps
  localparam int AREA_W = 23;  // area in 1/256 m^2
  localparam int DRAG_W = 32;
  localparam int CFG_W = 16;

  localparam logic [29:0] INV_GAIN = 30'd652032874;
  localparam logic [17:0] DRAG_COEF = 18'd169974;

  localparam logic [31:0] ATAN_TBL [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [2:0] {
    REG_WIND_SPEED = 3'd0,
    REG_WIND_FROM  = 3'd1,
    REG_HULL_BEAM  = 3'd2,
    REG_HULL_DRAUGHT = 3'd3,
    REG_HULL_LENGTH  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [RW-1:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic [VZW-1:0]       z;
    logic                 zero;
  } vec_t;

  // remove CORDIC gain: round(v * 2^30/K / 2^30)
  function automatic logic signed [RW-1:0] gain_fix(input logic signed [RW-1:0] v);
    logic signed [RW+30:0] prod;
    logic signed [RW+30:0] rnd;
    begin
      prod = v * $signed({1'b0, INV_GAIN});
      rnd  = prod + (RW+31)'(64'sd536870912);
      gain_fix = rnd[RW+29:30];
    end
  endfunction

endpackage

FILE: hdl/awd_rot_cell.sv
// One rotation-mode CORDIC stage, registered.
`timescale 1ns / 1ps
module awd_rot_cell import awd_pkg::*; (
  input  logic             clk_i,
  input  logic [STG_W-1:0] stage_i,
  input  rot_t             cur_i,
  output rot_t             nxt_o
);

  rot_t nxt_d, nxt_q;
  logic signed [RW-1:0] dx, dy, da;

  always_comb begin
    dx = cur_i.y >>> stage_i;
    dy = cur_i.x >>> stage_i;
    da = $signed({{(RW-32){1'b0}}, ATAN_TBL[5'(stage_i)]});
    nxt_d = cur_i;
    if (!cur_i.z[RW-1]) begin
      nxt_d.x = cur_i.x - dx;
      nxt_d.y = cur_i.y + dy;
      nxt_d.z = cur_i.z - da;
    end else begin
      nxt_d.x = cur_i.x + dx;
      nxt_d.y = cur_i.y - dy;
      nxt_d.z = cur_i.z + da;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q <= nxt_d;
  end

  assign nxt_o = nxt_q;

endmodule

FILE: hdl/awd_vec_cell.sv
// One vectoring-mode CORDIC stage, registered.
`timescale 1ns / 1ps
module awd_vec_cell import awd_pkg::*; (
  input  logic             clk_i,
  input  logic [STG_W-1:0] stage_i,
  input  vec_t             cur_i,
  output vec_t             nxt_o
);

  vec_t nxt_d, nxt_q;
  logic signed [VW-1:0] dx, dy;

  always_comb begin
    dx = cur_i.y >>> stage_i;
    dy = cur_i.x >>> stage_i;
    nxt_d = cur_i;
    if (!cur_i.y[VW-1]) begin
      nxt_d.x = cur_i.x + dx;
      nxt_d.y = cur_i.y - dy;
      nxt_d.z = cur_i.z + ATAN_TBL[5'(stage_i)];
    end else begin
      nxt_d.x = cur_i.x - dx;
      nxt_d.y = cur_i.y + dy;
      nxt_d.z = cur_i.z - ATAN_TBL[5'(stage_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q <= nxt_d;
  end

  assign nxt_o = nxt_q;

endmodule

FILE: hdl/awd_drag.sv
// Quadratic drag pipeline: square, area, coefficient and saturation, four stages.
`timescale 1ns / 1ps
module awd_drag import awd_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [RW-1:0]     rel_i,
  input  logic [AREA_W-1:0]        area_i,
  output logic signed [DRAG_W-1:0] drag_o
);

  typedef enum logic [1:0] {
    SGN_ZERO,
    SGN_POS,
    SGN_NEG
  } sgn_e;

  sgn_e sgn1_q, sgn2_q, sgn3_q, sgn1_d;
  logic signed [RW-1:0] rnd, r;
  logic [21:0] m_d, m_q;
  logic [44:0] sq;
  logic [29:0] s_d, s_q;
  logic [53:0] pr;
  logic [42:0] p_d, p_q;
  logic [61:0] fr;
  logic [33:0] f;
  logic signed [DRAG_W-1:0] drag_d, drag_q;

  // relative speed to 2^-12 kn, magnitude and sign
  always_comb begin
    rnd = rel_i + RW'(512);
    r   = rnd >>> 10;
    m_d = r[RW-1] ? 22'(-r) : r[21:0];
    if (r == '0) begin
      sgn1_d = SGN_ZERO;
    end else if (r[RW-1]) begin
      sgn1_d = SGN_NEG;
    end else begin
      sgn1_d = SGN_POS;
    end
  end

  always_comb begin
    sq  = 45'(m_q) * 45'(m_q) + 45'd8192;
    s_d = sq[43:14];
    pr  = 54'(s_q) * 54'(area_i) + 54'd512;
    p_d = pr[52:10];
    fr  = 62'(p_q) * 62'(DRAG_COEF) + 62'd134217728;
    f   = fr[61:28];
    unique case (sgn3_q)
      SGN_POS: drag_d = (f > 34'd2147483648) ? 32'sh80000000 : -$signed(f[31:0]);
      SGN_NEG: drag_d = (f > 34'd2147483647) ? 32'sh7fffffff : $signed(f[31:0]);
      default: drag_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    sgn1_q <= sgn1_d;
    s_q    <= s_d;
    sgn2_q <= sgn1_q;
    p_q    <= p_d;
    sgn3_q <= sgn2_q;
    drag_q <= drag_d;
  end

  assign drag_o = drag_q;

endmodule

FILE: hdl/apparent_wind_and_wind_drag.sv
// Top level: apparent wind and wind drag pipeline.
`timescale 1ns / 1ps
// Usage:
//   Items enter on start_i with heading_i, surge_speed_i, sway_speed_i and
//   water_speed_i; an item is taken at every edge where start_i is high,
//   busy_o stays low, so one item per cycle is sustained.
//   Each item gives one result, shown for a single cycle with result_valid_o.
//   The path is two CORDIC rows in series: one row of rotation cells (both
//   wind projections in parallel) feeding one row of vectoring cells, each
//   followed by a gain multiply stage.
//   Results come out in item order; the receiver cannot stall the block.
//   Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write wind speed, wind
//   source direction, beam, draught and length; indexes above 4 are ignored.
//   Write only while no item is in flight; area products follow in the next cycle.
//   Reset clears the registers to 0 and drops all items in flight.
module apparent_wind_and_wind_drag import awd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [15:0]              heading_i,
  input  logic signed [15:0]       surge_speed_i,
  input  logic signed [15:0]       sway_speed_i,
  input  logic signed [15:0]       water_speed_i,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  output logic                     result_valid_o,
  output logic signed [DRAG_W-1:0] axial_drag_o,
  output logic signed [DRAG_W-1:0] lateral_drag_o,
  output logic [15:0]              apparent_speed_o,
  output logic signed [15:0]       apparent_direction_o
);

  localparam int N = CORDIC_STAGES;
  localparam int LAT = 2 * N + 4;

  logic [13:0] wind_speed_q;
  logic [15:0] wind_from_q;
  logic [12:0] beam_q, length_q;
  logic [9:0]  draught_q;
  logic [AREA_W-1:0] area_front_q, area_side_q;

  logic accept;
  logic [LAT-1:0] vld_q;
  logic out_vld_q;

  rot_t rot_a0_d, rot_b0_d, rot_a0_q, rot_b0_q;
  wire rot_t rot_a [0:N];
  wire rot_t rot_b [0:N];

  logic signed [15:0] surge_q [0:N+1];
  logic signed [15:0] sway_q  [0:N+1];
  logic signed [15:0] water_q [0:N+1];

  logic signed [RW-1:0] ax_q, lat_q, wc_q, wsn_q;
  logic signed [RW-1:0] rel_ax, rel_lat;
  logic signed [DRAG_W-1:0] drag_ax, drag_lat;
  logic signed [DRAG_W-1:0] dax_q [0:DLY-1];
  logic signed [DRAG_W-1:0] dlat_q [0:DLY-1];

  vec_t vec0_d, vec0_q;
  wire vec_t vec [0:N];
  logic signed [VW-1:0] xs, ys;

  logic [64:0] pv;
  logic [65:0] pvr;
  logic [34:0] mag_d, mag_q;
  logic [VZW-1:0] vz_q;
  logic vzero_q;

  logic [35:0] spd_r;
  logic [VZW-1:0] dir_r;
  logic [15:0] spd_d, dir_d;

  logic signed [DRAG_W-1:0] axial_q, lateral_q;
  logic [15:0] speed_q, dir_q;

  // quadrant fold, then angle into 2^32 per turn
  function automatic rot_t prerot(input logic [15:0] ang, input logic [13:0] ws);
    logic [15:0] t;
    logic [15:0] a;
    logic signed [RW-1:0] m;
    rot_t v;
    begin
      t = ang + 16'h4000;
      m = $signed({{(RW-30){1'b0}}, ws, 16'h0000});
      a = t[15] ? ang + 16'h8000 : ang;
      v.x = t[15] ? -m : m;
      v.y = '0;
      v.z = $signed({{(RW-32){a[15]}}, a, 16'h0000});
      prerot = v;
    end
  endfunction

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wind_speed_q <= '0;
      wind_from_q  <= '0;
      beam_q       <= '0;
      draught_q    <= '0;
      length_q     <= '0;
      area_front_q <= '0;
      area_side_q  <= '0;
    end else begin
      area_front_q <= {10'b0, beam_q} * {13'b0, draught_q};
      area_side_q  <= {10'b0, length_q} * {13'b0, draught_q};
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_WIND_SPEED:   wind_speed_q <= cfg_data_i[13:0];
          REG_WIND_FROM:    wind_from_q  <= cfg_data_i[15:0];
          REG_HULL_BEAM:    beam_q       <= cfg_data_i[12:0];
          REG_HULL_DRAUGHT: draught_q    <= cfg_data_i[9:0];
          REG_HULL_LENGTH:  length_q     <= cfg_data_i[12:0];
          default: ;
        endcase
      end
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[LAT-2:0], accept};
      out_vld_q <= vld_q[LAT-1];
    end
  end

  // entry: axial frame uses the flow direction (source plus a half turn)
  always_comb begin
    rot_a0_d = prerot(wind_from_q + 16'h8000 - heading_i, wind_speed_q);
    rot_b0_d = prerot(wind_from_q - heading_i, wind_speed_q);
  end

  always_ff @(posedge clk_i) begin
    rot_a0_q   <= rot_a0_d;
    rot_b0_q   <= rot_b0_d;
    surge_q[0] <= surge_speed_i;
    sway_q[0]  <= sway_speed_i;
    water_q[0] <= water_speed_i;
    for (int k = 1; k <= N + 1; k++) begin
      surge_q[k] <= surge_q[k-1];
      sway_q[k]  <= sway_q[k-1];
      water_q[k] <= water_q[k-1];
    end
  end

  assign rot_a[0] = rot_a0_q;
  assign rot_b[0] = rot_b0_q;

  for (genvar k = 0; k < N; k++) begin : g_rot
    awd_rot_cell u_rot_a (
      .clk_i   (clk_i),
      .stage_i (STG_W'(k)),
      .cur_i   (rot_a[k]),
      .nxt_o   (rot_a[k+1])
    );
    awd_rot_cell u_rot_b (
      .clk_i   (clk_i),
      .stage_i (STG_W'(k)),
      .cur_i   (rot_b[k]),
      .nxt_o   (rot_b[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= gain_fix(rot_a[N].x);
    lat_q <= gain_fix(rot_a[N].y);
    wc_q  <= gain_fix(rot_b[N].x);
    wsn_q <= gain_fix(rot_b[N].y);
  end

  // drag on the relative wind
  assign rel_ax  = ax_q - $signed({{(RW-32){surge_q[N+1][15]}}, surge_q[N+1], 16'h0000});
  assign rel_lat = lat_q - $signed({{(RW-32){sway_q[N+1][15]}}, sway_q[N+1], 16'h0000});

  awd_drag u_drag_ax (
    .clk_i  (clk_i),
    .rel_i  (rel_ax),
    .area_i (area_front_q),
    .drag_o (drag_ax)
  );

  awd_drag u_drag_lat (
    .clk_i  (clk_i),
    .rel_i  (rel_lat),
    .area_i (area_side_q),
    .drag_o (drag_lat)
  );

  always_ff @(posedge clk_i) begin
    dax_q[0]  <= drag_ax;
    dlat_q[0] <= drag_lat;
    for (int k = 1; k < DLY; k++) begin
      dax_q[k]  <= dax_q[k-1];
      dlat_q[k] <= dlat_q[k-1];
    end
  end

  // apparent wind vector, folded into the right half plane
  always_comb begin
    xs = $signed({{(VW-32){water_q[N+1][15]}}, water_q[N+1], 16'h0000})
         + $signed({{(VW-RW){wc_q[RW-1]}}, wc_q});
    ys = $signed({{(VW-RW){wsn_q[RW-1]}}, wsn_q});
    vec0_d.zero = (xs == '0) && (ys == '0);
    if (xs[VW-1]) begin
      vec0_d.x = -xs;
      vec0_d.y = -ys;
      vec0_d.z = 32'h8000_0000;
    end else begin
      vec0_d.x = xs;
      vec0_d.y = ys;
      vec0_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    vec0_q <= vec0_d;
  end

  assign vec[0] = vec0_q;

  for (genvar k = 0; k < N; k++) begin : g_vec
    awd_vec_cell u_vec (
      .clk_i   (clk_i),
      .stage_i (STG_W'(k)),
      .cur_i   (vec[k]),
      .nxt_o   (vec[k+1])
    );
  end

  // magnitude gain removal; x is non-negative after vectoring
  always_comb begin
    pv    = vec[N].x[34:0] * INV_GAIN;
    pvr   = {1'b0, pv} + 66'd536870912;
    mag_d = pvr[64:30];
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    vz_q    <= vec[N].z;
    vzero_q <= vec[N].zero;
  end

  always_comb begin
    spd_r = {1'b0, mag_q} + 36'd32768;
    dir_r = vz_q + 32'h0000_8000;
    if (vzero_q) begin
      spd_d = '0;
      dir_d = '0;
    end else begin
      spd_d = (spd_r[35:32] != 4'd0) ? 16'hffff : spd_r[31:16];
      dir_d = dir_r[31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    axial_q   <= dax_q[DLY-1];
    lateral_q <= dlat_q[DLY-1];
    speed_q   <= spd_d;
    dir_q     <= dir_d;
  end

  assign result_valid_o       = out_vld_q;
  assign axial_drag_o         = axial_q;
  assign lateral_drag_o       = lateral_q;
  assign apparent_speed_o     = speed_q;
  assign apparent_direction_o = $signed(dir_q);

endmodule

FILE: bench/apparent_wind_and_wind_drag_tb.sv
// Self-checking bench for the apparent wind and wind drag pipeline.
`timescale 1ns / 1ps
module apparent_wind_and_wind_drag_tb import awd_pkg::*; ();

  localparam logic [2:0] REG_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;
  localparam longint INV_K = 64'sd652032874;
  localparam longint unsigned AIR_COEF = 64'd169974;
  localparam int SETTLE = 2 * CORDIC_STAGES + 10;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [15:0]        hd;
    logic signed [15:0] su;
    logic signed [15:0] sw;
    logic signed [15:0] wa;
  } ship_item_t;

  typedef struct {
    logic signed [31:0] ax;
    logic signed [31:0] lat;
    logic [15:0]        spd;
    logic signed [15:0] dir;
  } wind_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [15:0] heading_i = '0;
  logic signed [15:0] surge_speed_i = '0;
  logic signed [15:0] sway_speed_i = '0;
  logic signed [15:0] water_speed_i = '0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic busy_o, result_valid_o;
  logic signed [DRAG_W-1:0] axial_drag_o, lateral_drag_o;
  logic [15:0] apparent_speed_o;
  logic signed [15:0] apparent_direction_o;

  apparent_wind_and_wind_drag dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // local copy of the registers
  logic [13:0] m_ws = '0;
  logic [15:0] m_wf = '0;
  logic [12:0] m_beam = '0;
  logic [9:0]  m_draught = '0;
  logic [12:0] m_len = '0;

  ship_item_t pending_items[$];
  wind_res_t  expected_wind[$];
  bit quiet = 1'b0;
  bit failed = 1'b0;

  function automatic void wind_rotate(input longint mag, input logic [15:0] ang,
                                      output longint cx, output longint sy);
    longint x, y, z, dx, dy;
    logic [15:0] a;
    x = mag; y = 0; a = ang;
    if (16'(a + 16'h4000) >= 16'h8000) begin
      x = -x;
      a = 16'(a + 16'h8000);
    end
    z = longint'($signed(a)) * 65536;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'({32'd0, ATAN_TBL[i % 32]});
      end else begin
        x += dx; y -= dy; z += longint'({32'd0, ATAN_TBL[i % 32]});
      end
    end
    cx = (x * INV_K + (64'sd1 <<< 29)) >>> 30;
    sy = (y * INV_K + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint wind_force(input longint rel, input longint unsigned area);
    longint r;
    longint unsigned m, s, p, f;
    r = (rel + 512) >>> 10;
    m = (r < 0) ? -r : r;
    s = (m * m + 8192) >> 14;
    p = (s * area + 512) >> 10;
    f = (p * AIR_COEF + (64'd1 << 27)) >> 28;
    if (r == 0) return 0;
    if (r > 0) return (f > 64'd2147483648) ? -64'sd2147483648 : -longint'(f);
    return (f > 64'd2147483647) ? 64'sd2147483647 : longint'(f);
  endfunction

  function automatic wind_res_t predict_wind(input ship_item_t it);
    wind_res_t res;
    longint ws, ax, lat, wc, wsn, x, y, z, dx, dy, mag, spd;
    longint unsigned front, side;
    ws = longint'(m_ws) * 65536;
    front = longint'(m_beam) * longint'(m_draught);
    side = longint'(m_len) * longint'(m_draught);
    wind_rotate(ws, 16'(m_wf + 16'h8000 - it.hd), ax, lat);
    res.ax = 32'(wind_force(ax - longint'(it.su) * 65536, front));
    res.lat = 32'(wind_force(lat - longint'(it.sw) * 65536, side));
    wind_rotate(ws, 16'(m_wf - it.hd), wc, wsn);
    x = longint'(it.wa) * 65536 + wc;
    y = wsn;
    z = 0;
    if (x == 0 && y == 0) begin
      res.spd = '0;
      res.dir = '0;
    end else begin
      if (x < 0) begin
        x = -x; y = -y; z = 64'sd1 <<< 31;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'({32'd0, ATAN_TBL[i % 32]});
        end else begin
          x -= dx; y += dy; z -= longint'({32'd0, ATAN_TBL[i % 32]});
        end
      end
      mag = (x * INV_K + (64'sd1 <<< 29)) >>> 30;
      spd = (mag + 32768) >>> 16;
      if (spd < 0) spd = 0;
      if (spd > 65535) spd = 65535;
      res.spd = 16'(spd);
      res.dir = 16'((z + 32768) >>> 16);
    end
    return res;
  endfunction

  // driver: one item per accepted start
  ship_item_t cur;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        expected_wind.push_back(predict_wind(cur));
      if (start_i && busy_o) begin
        // hold the item until taken
      end else if (pending_items.size() > 0 && (quiet || $urandom_range(0, 99) >= 36)) begin
        cur = pending_items.pop_front();
        heading_i <= cur.hd;
        surge_speed_i <= cur.su;
        sway_speed_i <= cur.sw;
        water_speed_i <= cur.wa;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  int stall = 0;
  wind_res_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o || (start_i && !busy_o)) stall <= 0;
      else stall <= stall + 1;
      if (stall >= STALL_LIMIT) begin
        $display("apparent_wind_and_wind_drag_tb: FAIL");
        $finish;
      end
      if (result_valid_o) begin
        if (expected_wind.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected result ax=%0d lat=%0d", $realtime, axial_drag_o,
                   lateral_drag_o);
        end else begin
          want = expected_wind.pop_front();
          if (axial_drag_o !== want.ax) begin
            failed = 1'b1;
            $display("%0t: axial_drag exp %0d got %0d", $realtime, want.ax, axial_drag_o);
          end
          if (lateral_drag_o !== want.lat) begin
            failed = 1'b1;
            $display("%0t: lateral_drag exp %0d got %0d", $realtime, want.lat,
                     lateral_drag_o);
          end
          if (apparent_speed_o !== want.spd) begin
            failed = 1'b1;
            $display("%0t: apparent_speed exp %0d got %0d", $realtime, want.spd,
                     apparent_speed_o);
          end
          if (apparent_direction_o !== want.dir) begin
            failed = 1'b1;
            $display("%0t: apparent_direction exp %0d got %0d", $realtime, want.dir,
                     apparent_direction_o);
          end
        end
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_WIND_SPEED:   m_ws = val[13:0];
      REG_WIND_FROM:    m_wf = val;
      REG_HULL_BEAM:    m_beam = val[12:0];
      REG_HULL_DRAUGHT: m_draught = val[9:0];
      REG_HULL_LENGTH:  m_len = val[12:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_wind(input logic [15:0] ws, wf, beam, dr, len);
    cfg_write(REG_WIND_SPEED, ws);
    cfg_write(REG_WIND_FROM, wf);
    cfg_write(REG_HULL_BEAM, beam);
    cfg_write(REG_HULL_DRAUGHT, dr);
    cfg_write(REG_HULL_LENGTH, len);
    cfg_write($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, 16'($urandom));
    repeat (3) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || start_i || expected_wind.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic add_item(input logic [15:0] hd, input logic [15:0] su, sw, wa);
    ship_item_t it;
    it.hd = hd; it.su = su; it.sw = sw; it.wa = wa;
    pending_items.push_back(it);
  endtask

  function automatic logic [15:0] near_wind();
    int lim;
    lim = int'(m_ws) + 8;
    return 16'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  task automatic add_random();
    if ($urandom_range(0, 3) == 0)
      add_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      add_item(16'($urandom), near_wind(), near_wind(), near_wind());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset config: still air, zero vector, astern wind, field extremes
    add_item(16'h0000, 16'sd0, 16'sd0, 16'sd0);
    add_item(16'hFFFF, 16'sd0, 16'sd0, -16'sd5);
    add_item(16'h8000, -16'sd32768, 16'sd32767, -16'sd32768);
    add_item(16'h4000, 16'sd32767, -16'sd32768, 16'sd32767);
    add_item(16'h0001, 16'sd1, -16'sd1, 16'sd1);
    wait_drained();
    // biggest hull and wind, drag saturation
    set_wind(16'd12800, 16'h0000, 16'd8191, 16'd1023, 16'd8191);
    add_item(16'h0000, 16'sd0, 16'sd0, 16'sd0);
    add_item(16'h0000, -16'sd32768, -16'sd32768, -16'sd32768);
    add_item(16'h8000, 16'sd32767, 16'sd32767, 16'sd32767);
    add_item(16'h4000, 16'sd0, 16'sd0, 16'sd0);
    add_item(16'hC000, -16'sd12800, 16'sd12800, -16'sd12800);
    add_item(16'h8000, 16'sd12800, 16'sd0, 16'sd12800);
    add_item(16'hFFFF, 16'sd100, -16'sd100, 16'sd0);
    add_item(16'h2000, 16'sd0, 16'sd0, -16'sd32768);
    wait_drained();
    // registers over range are masked
    set_wind(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_item(16'h7FFF, 16'sd0, 16'sd0, 16'sd0);
    add_item(16'h0000, -16'sd32768, 16'sd32767, 16'sd0);
    add_item(16'hFFFF, 16'sd16383, -16'sd16383, -16'sd16383);
    wait_drained();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0)
        set_wind(16'd0, 16'($urandom), 16'd8191, 16'd1023, 16'd8191);
      else if (ph == 1)
        set_wind(16'd12800, 16'($urandom), 16'd0, 16'd0, 16'd0);
      else
        set_wind(16'($urandom_range(0, 12800)), 16'($urandom), 16'($urandom_range(0, 8191)),
                 16'($urandom_range(0, 1023)), 16'($urandom_range(0, 8191)));
      quiet = (ph == 5);
      for (int n = 0; n < 195; n++) begin
        add_random();
        if (ph == 3 && n == 100) begin
          // let the pipe empty fully before going on
          while (pending_items.size() > 0 || start_i || expected_wind.size() > 0)
            @(posedge clk_i);
        end
      end
      wait_drained();
    end
    if (!failed)
      $display("apparent_wind_and_wind_drag_tb: PASS");
    else
      $display("apparent_wind_and_wind_drag_tb: FAIL");
    $finish;
  end

endmodule
